FILE: hdl/triangle_span_generator_assert.svh
// Assertion macros for the span generator checker.
`ifndef TRIANGLE_SPAN_GENERATOR_ASSERT_SVH
`define TRIANGLE_SPAN_GENERATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/tsg_pkg.sv
package tsg_pkg;

	// action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	localparam int STRIDE_W = 13;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd640;
	localparam int SLOPE_W = 32;

	// microcode
	localparam int UADDR_W = 5;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_SORT,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_DIV_STORE,
		OP_SET_PHASE,
		OP_SPAN_XB,
		OP_SPAN_XE,
		OP_SPAN_OUT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_JUMP,
		COND_DISPATCH,
		COND_SKIP,
		COND_DIV_DONE,
		COND_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t                  op;
		logic [1:0]           sel;
		cond_t                cond;
		logic [UADDR_W-1:0]   target;
	} ucode_t;

	localparam logic [UADDR_W-1:0] UA_IDLE = 5'd0;
	localparam logic [UADDR_W-1:0] UA_LOAD = 5'd1;
	localparam logic [UADDR_W-1:0] UA_SLOPE0 = 5'd4;
	localparam logic [UADDR_W-1:0] UA_SLOPE1 = 5'd7;
	localparam logic [UADDR_W-1:0] UA_SLOPE2 = 5'd10;
	localparam logic [UADDR_W-1:0] UA_SLOPE3 = 5'd13;
	localparam logic [UADDR_W-1:0] UA_PHASE = 5'd16;
	localparam logic [UADDR_W-1:0] UA_SPAN = 5'd17;

	function automatic ucode_t uw(input op_t op, input logic [1:0] sel, input cond_t cond,
			input logic [UADDR_W-1:0] target);
		ucode_t w;
		w.op = op;
		w.sel = sel;
		w.cond = cond;
		w.target = target;
		return w;
	endfunction

	// control store
	function automatic ucode_t ucode_rom(input logic [UADDR_W-1:0] addr);
		ucode_t w;
		unique case (addr)
			5'd0:  w = uw(OP_IDLE,      2'd0, COND_DISPATCH, UA_LOAD);
			5'd1:  w = uw(OP_SORT,      2'd0, COND_NEXT,     UA_IDLE);
			5'd2:  w = uw(OP_SORT,      2'd1, COND_NEXT,     UA_IDLE);
			5'd3:  w = uw(OP_SORT,      2'd0, COND_NEXT,     UA_IDLE);
			5'd4:  w = uw(OP_DIV_START, 2'd0, COND_SKIP,     UA_SLOPE1);
			5'd5:  w = uw(OP_DIV_STEP,  2'd0, COND_DIV_DONE, UA_IDLE);
			5'd6:  w = uw(OP_DIV_STORE, 2'd0, COND_NEXT,     UA_IDLE);
			5'd7:  w = uw(OP_DIV_START, 2'd1, COND_SKIP,     UA_SLOPE2);
			5'd8:  w = uw(OP_DIV_STEP,  2'd1, COND_DIV_DONE, UA_IDLE);
			5'd9:  w = uw(OP_DIV_STORE, 2'd1, COND_NEXT,     UA_IDLE);
			5'd10: w = uw(OP_DIV_START, 2'd2, COND_SKIP,     UA_SLOPE3);
			5'd11: w = uw(OP_DIV_STEP,  2'd2, COND_DIV_DONE, UA_IDLE);
			5'd12: w = uw(OP_DIV_STORE, 2'd2, COND_NEXT,     UA_IDLE);
			5'd13: w = uw(OP_DIV_START, 2'd3, COND_SKIP,     UA_PHASE);
			5'd14: w = uw(OP_DIV_STEP,  2'd3, COND_DIV_DONE, UA_IDLE);
			5'd15: w = uw(OP_DIV_STORE, 2'd3, COND_NEXT,     UA_IDLE);
			5'd16: w = uw(OP_SET_PHASE, 2'd0, COND_JUMP,     UA_IDLE);
			5'd17: w = uw(OP_SPAN_XB,   2'd0, COND_NEXT,     UA_IDLE);
			5'd18: w = uw(OP_SPAN_XE,   2'd0, COND_NEXT,     UA_IDLE);
			5'd19: w = uw(OP_SPAN_OUT,  2'd0, COND_OUT_FREE, UA_IDLE);
			default: w = uw(OP_IDLE,    2'd0, COND_JUMP,     UA_IDLE);
		endcase
		return w;
	endfunction

endpackage

FILE: hdl/triangle_span_generator.sv
// Scanline triangle span generator. A load transfer (action 0) takes three
// signed vertices, sorts them by y and computes four inverse edge slopes in
// signed fixed point (SLOPE_FRAC_BITS fraction bits, quotient truncated toward
// zero, saturated to 32 bits). Each step transfer (action 1) then yields one
// span: row, ordered begin/end x, start index (x + row * line_stride) and a
// last-span flag; the upper half runs y0..y1, the lower half y2 down to y1+1.
// A step with no triangle in progress is taken and yields nothing; a load
// drops any triangle in progress. A load keeps in_stall high through the sort,
// the four divisions and the phase setup; both divisions of a flat half are
// skipped. The single shared divider retires one quotient bit per cycle. A
// step transfer runs the XB, XE and OUT states, which share the one slope
// multiplier; in_stall stays high until the span enters the output register,
// and the span waits for that while a held result is stalled by out_stall.
// line_stride is written through cfg_we/cfg_wdata; write it only while the
// block is idle, as the block itself does not enforce this.
module triangle_span_generator #(
	parameter int COORD_BITS = 12,
	parameter int SLOPE_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_we,
	input  logic [tsg_pkg::STRIDE_W-1:0]          cfg_wdata,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  action,
	input  logic signed [COORD_BITS-1:0]          vertex_a_x,
	input  logic signed [COORD_BITS-1:0]          vertex_a_y,
	input  logic signed [COORD_BITS-1:0]          vertex_b_x,
	input  logic signed [COORD_BITS-1:0]          vertex_b_y,
	input  logic signed [COORD_BITS-1:0]          vertex_c_x,
	input  logic signed [COORD_BITS-1:0]          vertex_c_y,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [COORD_BITS-1:0]          span_row,
	output logic signed [COORD_BITS:0]            span_x_begin,
	output logic signed [COORD_BITS:0]            span_x_end,
	output logic signed [2*COORD_BITS:0]          start_index,
	output logic                                  last_span
);

	localparam int C = COORD_BITS;
	localparam int F = SLOPE_FRAC_BITS;
	localparam int SW = tsg_pkg::SLOPE_W;
	localparam int XW = C + 1;                 // coordinate differences
	localparam int N = C + 1 + F;              // dividend / quotient bits
	localparam int CNTW = $clog2(N + 1);
	localparam int SATW = (N + 1 > SW + 1) ? N + 1 : SW + 1;
	localparam int PRODW = XW + SW;            // distance * slope
	localparam int FW = C + SW + 2;            // base<<F + product
	localparam int TW = FW - F;                // truncated edge x
	localparam int IW = 2 * C + 1;             // start index
	localparam int RSW = C + tsg_pkg::STRIDE_W + 1;
	localparam int PW = 2 * C + SW + 8;        // index sum, wide enough for all terms

	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(N - 1);
	localparam logic signed [SATW-1:0] SAT_MAX = {{(SATW-SW){1'b0}}, 1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SATW-1:0] SAT_MIN = {{(SATW-SW){1'b1}}, 1'b1, {(SW-1){1'b0}}};
	localparam logic [FW-1:0] TRUNC_BIAS = {{(FW-F){1'b0}}, {F{1'b1}}};

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_UPPER,
		PH_LOWER
	} phase_t;

	// sequencer
	logic [tsg_pkg::UADDR_W-1:0] upc_q, upc_d;
	tsg_pkg::ucode_t uc;

	// triangle state
	phase_t phase_q;
	logic signed [C-1:0] row_q;
	logic signed [C-1:0] vx_q [3];
	logic signed [C-1:0] vy_q [3];
	logic signed [SW-1:0] slope_q [4];
	logic [tsg_pkg::STRIDE_W-1:0] stride_q;

	// divider
	logic [N-1:0] div_num_q;
	logic [XW-1:0] div_rem_q;
	logic [XW-1:0] div_den_q;
	logic div_neg_q;
	logic [CNTW-1:0] div_cnt_q;

	// span datapath
	logic signed [PRODW-1:0] prod_q;
	logic signed [TW-1:0] xb_q, xe_q;
	logic signed [RSW-1:0] rs_q;

	logic in_xfer, out_free, part_unused;

	assign uc = tsg_pkg::ucode_rom(upc_q);
	assign in_stall = (uc.op != tsg_pkg::OP_IDLE);
	assign in_xfer = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	// upper half needs y0 != y1, lower half y1 != y2
	assign part_unused = uc.sel[1] ? (vy_q[1] == vy_q[2]) : (vy_q[0] == vy_q[1]);

	// ---- divider operands ----
	logic signed [XW-1:0] dx, dy;
	logic [XW-1:0] dx_mag;
	always_comb begin
		unique case (uc.sel)
			2'd0: begin
				dx = XW'(vx_q[1]) - XW'(vx_q[0]);
				dy = XW'(vy_q[1]) - XW'(vy_q[0]);
			end
			2'd1: begin
				dx = XW'(vx_q[2]) - XW'(vx_q[0]);
				dy = XW'(vy_q[2]) - XW'(vy_q[0]);
			end
			2'd2: begin
				dx = XW'(vx_q[0]) - XW'(vx_q[2]);
				dy = XW'(vy_q[2]) - XW'(vy_q[0]);
			end
			default: begin
				dx = XW'(vx_q[1]) - XW'(vx_q[2]);
				dy = XW'(vy_q[2]) - XW'(vy_q[1]);
			end
		endcase
		dx_mag = dx[XW-1] ? XW'(-dx) : XW'(dx);
	end

	// restoring divide, one quotient bit per cycle
	logic [XW:0] rem_sh, rem_diff;
	logic rem_ge;
	assign rem_sh = {div_rem_q, div_num_q[N-1]};
	assign rem_diff = rem_sh - {1'b0, div_den_q};
	assign rem_ge = (rem_sh >= {1'b0, div_den_q});

	// sign and saturate the finished quotient
	logic signed [SATW-1:0] q_mag, q_val;
	logic signed [SW-1:0] q_sat;
	always_comb begin
		q_mag = {{(SATW-N){1'b0}}, div_num_q};
		q_val = div_neg_q ? -q_mag : q_mag;
		if (q_val > SAT_MAX)
			q_sat = SAT_MAX[SW-1:0];
		else if (q_val < SAT_MIN)
			q_sat = SAT_MIN[SW-1:0];
		else
			q_sat = q_val[SW-1:0];
	end

	// ---- span datapath ----
	logic upper;
	logic signed [XW-1:0] row_dist;
	logic signed [C-1:0] base_x;
	logic signed [SW-1:0] slope_b, slope_e, mul_slope;
	logic signed [PRODW-1:0] prod;
	logic signed [FW-1:0] full, full_adj;
	logic signed [TW-1:0] xt;
	logic signed [RSW-1:0] rs;

	assign upper = (phase_q == PH_UPPER);
	assign row_dist = upper ? XW'(row_q) - XW'(vy_q[0]) : XW'(vy_q[2]) - XW'(row_q);
	assign base_x = upper ? vx_q[0] : vx_q[2];
	assign slope_b = upper ? slope_q[0] : slope_q[2];
	assign slope_e = upper ? slope_q[1] : slope_q[3];
	// idle cycles prime the begin-edge product; the XB step stores begin x and forms the end-edge product
	assign mul_slope = (uc.op == tsg_pkg::OP_SPAN_XB) ? slope_e : slope_b;
	assign prod = PRODW'(row_dist) * PRODW'(mul_slope);
	// edge x = base<<F + product, truncated toward zero
	assign full = (FW'(base_x) <<< F) + FW'(prod_q);
	assign full_adj = full + (full[FW-1] ? TRUNC_BIAS : '0);
	assign xt = full_adj[FW-1:F];
	assign rs = RSW'(row_q) * RSW'($signed({1'b0, stride_q}));

	// ordering and index for the output register
	logic signed [TW-1:0] x_lo, x_hi;
	logic signed [PW-1:0] idx_sum;
	assign x_lo = (xb_q > xe_q) ? xe_q : xb_q;
	assign x_hi = (xb_q > xe_q) ? xb_q : xe_q;
	assign idx_sum = PW'(x_lo) + PW'(rs_q);

	// row advance
	logic signed [XW-1:0] y1_next;
	logic at_last;
	phase_t phase_nx;
	logic signed [C-1:0] row_nx;
	assign y1_next = XW'(vy_q[1]) + XW'(1);
	always_comb begin
		at_last = 1'b0;
		phase_nx = phase_q;
		row_nx = row_q;
		if (upper) begin
			if (row_q == vy_q[1]) begin
				if (vy_q[1] != vy_q[2]) begin
					phase_nx = PH_LOWER;
					row_nx = vy_q[2];
				end else begin
					phase_nx = PH_IDLE;
					at_last = 1'b1;
				end
			end else begin
				row_nx = row_q + C'(1);
			end
		end else begin
			if (XW'(row_q) <= y1_next) begin
				phase_nx = PH_IDLE;
				at_last = 1'b1;
			end else begin
				row_nx = row_q - C'(1);
			end
		end
	end

	// ---- next microinstruction ----
	always_comb begin
		unique case (uc.cond)
			tsg_pkg::COND_NEXT:
				upc_d = upc_q + tsg_pkg::UADDR_W'(1);
			tsg_pkg::COND_JUMP:
				upc_d = uc.target;
			tsg_pkg::COND_DISPATCH: begin
				if (in_xfer && action == tsg_pkg::ACT_LOAD)
					upc_d = uc.target;
				else if (in_xfer && phase_q != PH_IDLE)
					upc_d = tsg_pkg::UA_SPAN;
				else
					upc_d = upc_q;
			end
			tsg_pkg::COND_SKIP:
				upc_d = part_unused ? uc.target : upc_q + tsg_pkg::UADDR_W'(1);
			tsg_pkg::COND_DIV_DONE:
				upc_d = (div_cnt_q == '0) ? upc_q + tsg_pkg::UADDR_W'(1) : upc_q;
			tsg_pkg::COND_OUT_FREE:
				upc_d = out_free ? uc.target : upc_q;
			default:
				upc_d = tsg_pkg::UA_IDLE;
		endcase
	end

	// ---- control state and output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= tsg_pkg::UA_IDLE;
			phase_q <= PH_IDLE;
			row_q <= '0;
			stride_q <= tsg_pkg::STRIDE_RESET;
			out_valid <= 1'b0;
			span_row <= '0;
			span_x_begin <= '0;
			span_x_end <= '0;
			start_index <= '0;
			last_span <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (cfg_we)
				stride_q <= cfg_wdata;
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (uc.op)
				tsg_pkg::OP_SET_PHASE: begin
					if (vy_q[0] != vy_q[1]) begin
						phase_q <= PH_UPPER;
						row_q <= vy_q[0];
					end else if (vy_q[1] != vy_q[2]) begin
						phase_q <= PH_LOWER;
						row_q <= vy_q[2];
					end else begin
						phase_q <= PH_IDLE;
						row_q <= '0;
					end
				end
				tsg_pkg::OP_SPAN_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						span_row <= row_q;
						span_x_begin <= x_lo[XW-1:0];
						span_x_end <= x_hi[XW-1:0];
						start_index <= idx_sum[IW-1:0];
						last_span <= at_last;
						phase_q <= phase_nx;
						row_q <= row_nx;
					end
				end
				default: ;
			endcase
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		unique case (uc.op)
			tsg_pkg::OP_IDLE: begin
				prod_q <= prod;
				if (in_xfer && action == tsg_pkg::ACT_LOAD) begin
					vx_q[0] <= vertex_a_x;
					vy_q[0] <= vertex_a_y;
					vx_q[1] <= vertex_b_x;
					vy_q[1] <= vertex_b_y;
					vx_q[2] <= vertex_c_x;
					vy_q[2] <= vertex_c_y;
				end
			end
			tsg_pkg::OP_SORT: begin
				// compare-and-swap; equal y keeps order
				if (uc.sel == 2'd0) begin
					if (vy_q[0] > vy_q[1]) begin
						vx_q[0] <= vx_q[1];
						vy_q[0] <= vy_q[1];
						vx_q[1] <= vx_q[0];
						vy_q[1] <= vy_q[0];
					end
				end else begin
					if (vy_q[1] > vy_q[2]) begin
						vx_q[1] <= vx_q[2];
						vy_q[1] <= vy_q[2];
						vx_q[2] <= vx_q[1];
						vy_q[2] <= vy_q[1];
					end
				end
			end
			tsg_pkg::OP_DIV_START: begin
				slope_q[uc.sel] <= '0;   // stays zero when the half is flat
				div_neg_q <= dx[XW-1];
				div_num_q <= {dx_mag, {F{1'b0}}};
				div_rem_q <= '0;
				div_den_q <= dy;
				div_cnt_q <= CNT_LAST;
			end
			tsg_pkg::OP_DIV_STEP: begin
				div_rem_q <= rem_ge ? rem_diff[XW-1:0] : rem_sh[XW-1:0];
				div_num_q <= {div_num_q[N-2:0], rem_ge};
				div_cnt_q <= div_cnt_q - CNTW'(1);
			end
			tsg_pkg::OP_DIV_STORE:
				slope_q[uc.sel] <= q_sat;
			tsg_pkg::OP_SPAN_XB: begin
				xb_q <= xt;
				prod_q <= prod;
			end
			tsg_pkg::OP_SPAN_XE: begin
				xe_q <= xt;
				rs_q <= rs;
			end
			default: ;
		endcase
	end

endmodule

FILE: hdl/tsg_checker.sv
`include "triangle_span_generator_assert.svh"

module tsg_checker #(
	parameter int COORD_BITS = 12
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         action,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [COORD_BITS-1:0] span_row,
	input logic signed [COORD_BITS:0]   span_x_begin,
	input logic signed [COORD_BITS:0]   span_x_end,
	input logic signed [2*COORD_BITS:0] start_index,
	input logic                         last_span
);

	logic load_xfer, step_xfer;
	assign load_xfer = in_valid && !in_stall && action == tsg_pkg::ACT_LOAD;
	assign step_xfer = in_valid && !in_stall && action == tsg_pkg::ACT_STEP;

	// held result must not move
	`TSG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(span_row) && $stable(span_x_begin) && $stable(span_x_end) && $stable(start_index) && $stable(last_span), "stalled span changed")

	// span ends come out in order
	`TSG_ASSERT_NOW(a_span_order, clk, arst_n, out_valid, $signed(span_x_begin) <= $signed(span_x_end), "span begin beyond end")

	// a load starts setup: busy, and no span appears
	`TSG_ASSERT_NEXT(a_load_busy, clk, arst_n, load_xfer, in_stall && !$rose(out_valid), "load transfer not followed by setup")

	// a fresh span follows a step transfer that ran through XB, XE and OUT
	`TSG_ASSERT_NOW(a_span_src, clk, arst_n, $rose(out_valid), $past(step_xfer, 4), "span without step transfer")

endmodule

bind triangle_span_generator tsg_checker #(.COORD_BITS(COORD_BITS)) u_tsg_checker (.*);
